// File: rtl/grm_pkg.sv
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types and constants for the greedy rectangle merge core.
// ----------------------------------------------------------------------------
package grm_pkg;

    // Fixed field widths of the item and result ports
    localparam int ROW_W  = 5;
    localparam int COL_W  = 5;
    localparam int SIZE_W = 6;
    localparam int MAT_W  = 8;
    localparam int CFG_W  = 6;

    // Item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Configuration register indexes
    localparam logic [0:0] REG_ROW_COUNT = 1'b0;
    localparam logic [0:0] REG_COL_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] ROW_COUNT_RST = 6'd32;
    localparam logic [CFG_W-1:0] COL_COUNT_RST = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_CK,
        ST_RUN,
        ST_RUN_CK,
        ST_ROW,
        ST_ROW_CK,
        ST_CLEAR
    } grm_state_t;

    typedef struct packed {
        logic              found;
        logic [ROW_W-1:0]  rect_row;
        logic [COL_W-1:0]  rect_col;
        logic [SIZE_W-1:0] rect_width;
        logic [SIZE_W-1:0] rect_height;
        logic [MAT_W-1:0]  rect_material;
    } grm_result_t;

endpackage

// File: rtl/greedy_rectangle_merge_core.sv
// ----------------------------------------------------------------------------
// greedy_rectangle_merge_core
// Merges a grid of material codes into rectangles, one per fetch item.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start/op/cell_* when start is high and busy is low.
//   A load item (op=0) writes one cell and rewinds the scan cursor and gives
//   no result.
//   A fetch item (op=1) scans from the cursor for the next nonzero cell, grows
//   a run right, then whole rows down, clears the covered cells and reports
//   found/rect_* with a one-cycle done strobe; found=0 when none is left.
//   A fetch scans, compares and clears cells one at a time; the single
//   cell-memory port, one cell access per step, sets how long it takes.
//   The next item may be issued in the cycle done is high.
//   row_count/col_count are written through cfg_we/cfg_index/cfg_data while
//   idle. Reset sets both extents to 32 and the cursor to the first cell; the
//   cell memory holds no defined contents until loaded. Results are not held:
//   the receiver takes each one in the cycle it is shown.
// ----------------------------------------------------------------------------
module greedy_rectangle_merge_core #(
    parameter int GRID_DIM      = 32,
    parameter int MATERIAL_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       op,
    input  logic [grm_pkg::ROW_W-1:0]  cell_row,
    input  logic [grm_pkg::COL_W-1:0]  cell_col,
    input  logic [grm_pkg::MAT_W-1:0]  cell_material,
    output logic                       done,
    output logic                       found,
    output logic [grm_pkg::ROW_W-1:0]  rect_row,
    output logic [grm_pkg::COL_W-1:0]  rect_col,
    output logic [grm_pkg::SIZE_W-1:0] rect_width,
    output logic [grm_pkg::SIZE_W-1:0] rect_height,
    output logic [grm_pkg::MAT_W-1:0]  rect_material,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [grm_pkg::CFG_W-1:0]  cfg_data
);

    import grm_pkg::*;

    localparam int IDX_W  = $clog2(GRID_DIM);
    localparam int CNT_W  = $clog2(GRID_DIM + 1);
    localparam int ADDR_W = 2 * IDX_W;

    logic [CFG_W-1:0]         row_count_reg, row_count_next;
    logic [CFG_W-1:0]         col_count_reg, col_count_next;
    logic [CNT_W-1:0]         rows, cols;
    grm_result_t              result;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
    logic [MATERIAL_BITS-1:0] ram_wdata, ram_rdata;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_next = cfg_data;
                REG_COL_COUNT: col_count_next = cfg_data;
                default:       row_count_next = row_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // extents above the grid size act as the grid size
    always_comb
    begin
        rows = (int'(row_count_reg) > GRID_DIM) ? CNT_W'(GRID_DIM) : CNT_W'(row_count_reg);
        cols = (int'(col_count_reg) > GRID_DIM) ? CNT_W'(GRID_DIM) : CNT_W'(col_count_reg);
    end

    grm_ram #(
        .WIDTH (MATERIAL_BITS),
        .DEPTH (2 ** ADDR_W)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    grm_ctrl #(
        .GRID_DIM      (GRID_DIM),
        .MATERIAL_BITS (MATERIAL_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .op            (op),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .cell_material (cell_material),
        .rows          (rows),
        .cols          (cols),
        .busy          (busy),
        .done          (done),
        .result        (result),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    assign found         = result.found;
    assign rect_row      = result.rect_row;
    assign rect_col      = result.rect_col;
    assign rect_width    = result.rect_width;
    assign rect_height   = result.rect_height;
    assign rect_material = result.rect_material;

endmodule

// File: rtl/grm_ram.sv
// ----------------------------------------------------------------------------
// grm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module grm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/grm_ctrl.sv
// ----------------------------------------------------------------------------
// grm_ctrl
// Sequencer and shared address/compare unit: scans, grows and clears one
// rectangle per fetch, one grid cell per memory access.
// ----------------------------------------------------------------------------
module grm_ctrl #(
    parameter int GRID_DIM      = 32,
    parameter int MATERIAL_BITS = 8,
    localparam int IDX_W  = $clog2(GRID_DIM),
    localparam int CNT_W  = $clog2(GRID_DIM + 1),
    localparam int ADDR_W = 2 * IDX_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      op,
    input  logic [grm_pkg::ROW_W-1:0] cell_row,
    input  logic [grm_pkg::COL_W-1:0] cell_col,
    input  logic [grm_pkg::MAT_W-1:0] cell_material,
    input  logic [CNT_W-1:0]          rows,
    input  logic [CNT_W-1:0]          cols,
    output logic                      busy,
    output logic                      done,
    output grm_pkg::grm_result_t      result,
    output logic                      ram_we,
    output logic [ADDR_W-1:0]         ram_waddr,
    output logic [MATERIAL_BITS-1:0]  ram_wdata,
    output logic [ADDR_W-1:0]         ram_raddr,
    input  logic [MATERIAL_BITS-1:0]  ram_rdata
);

    import grm_pkg::*;

    // cursor arithmetic needs room for GRID_DIM + offsets up to GRID_DIM
    localparam int S_W = CNT_W + 1;

    grm_state_t               state_reg, state_next;
    logic [S_W-1:0]           row_reg, row_next;
    logic [S_W-1:0]           col_reg, col_next;
    logic [CNT_W-1:0]         w_reg, w_next;
    logic [CNT_W-1:0]         h_reg, h_next;
    logic [IDX_W-1:0]         i_reg, i_next;
    logic [IDX_W-1:0]         j_reg, j_next;
    logic [MATERIAL_BITS-1:0] mat_reg, mat_next;
    grm_result_t              res_reg, res_next;
    logic                     done_reg, done_next;

    logic [S_W-1:0]   rows_x, cols_x;
    logic             wrap;
    logic [S_W-1:0]   row_eff, col_eff;
    logic [S_W-1:0]   base_r, base_c;
    logic [CNT_W-1:0] off_r, off_c;
    logic [S_W-1:0]   sum_r, sum_c;
    logic [ADDR_W-1:0] addr;
    logic             row_in, col_in;
    logic             match, nonzero;
    logic             j_last, i_last;
    logic             empty_cols;
    logic             load_in_range;

    // Shared address unit and comparator
    always_comb
    begin
        rows_x     = S_W'(rows);
        cols_x     = S_W'(cols);
        empty_cols = (cols == '0);
        wrap       = (col_reg >= cols_x);
        row_eff    = wrap ? (row_reg + S_W'(1)) : row_reg;
        col_eff    = wrap ? '0 : col_reg;

        base_r = row_reg;
        base_c = col_reg;
        off_r  = '0;
        off_c  = '0;
        unique case (state_reg)
            ST_SCAN:
            begin
                base_r = row_eff;
                base_c = col_eff;
            end
            ST_RUN:
            begin
                off_c = w_reg;
            end
            ST_ROW:
            begin
                off_r = h_reg;
                off_c = CNT_W'(j_reg);
            end
            ST_CLEAR:
            begin
                off_r = CNT_W'(i_reg);
                off_c = CNT_W'(j_reg);
            end
            default:
            begin
                off_r = '0;
            end
        endcase

        sum_r   = base_r + S_W'(off_r);
        sum_c   = base_c + S_W'(off_c);
        addr    = {sum_r[IDX_W-1:0], sum_c[IDX_W-1:0]};
        row_in  = (sum_r < rows_x);
        col_in  = (sum_c < cols_x);
        match   = (ram_rdata == mat_reg);
        nonzero = (ram_rdata != '0);
        j_last  = ((CNT_W'(j_reg) + CNT_W'(1)) == w_reg);
        i_last  = ((CNT_W'(i_reg) + CNT_W'(1)) == h_reg);

        load_in_range = (int'(cell_row) < GRID_DIM) && (int'(cell_col) < GRID_DIM);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (op == OP_FETCH))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = (!row_in || empty_cols) ? ST_IDLE : ST_SCAN_CK;
            end
            ST_SCAN_CK:
            begin
                state_next = nonzero ? ST_RUN : ST_SCAN;
            end
            ST_RUN:
            begin
                state_next = col_in ? ST_RUN_CK : ST_ROW;
            end
            ST_RUN_CK:
            begin
                state_next = match ? ST_RUN : ST_ROW;
            end
            ST_ROW:
            begin
                state_next = row_in ? ST_ROW_CK : ST_CLEAR;
            end
            ST_ROW_CK:
            begin
                state_next = match ? ST_ROW : ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (j_last && i_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and memory controls
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        mat_next  = mat_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr;
        ram_wdata = '0;
        ram_raddr = addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (op == OP_LOAD))
                begin
                    ram_we    = load_in_range;
                    ram_waddr = {IDX_W'(cell_row), IDX_W'(cell_col)};
                    ram_wdata = MATERIAL_BITS'(cell_material);
                    row_next  = '0;
                    col_next  = '0;
                end
            end
            ST_SCAN:
            begin
                row_next = row_eff;
                col_next = col_eff;
                if (!row_in || empty_cols)
                begin
                    // grid exhausted: park cursor at the end
                    row_next  = S_W'(GRID_DIM);
                    col_next  = '0;
                    res_next  = '0;
                    done_next = 1'b1;
                end
            end
            ST_SCAN_CK:
            begin
                if (nonzero)
                begin
                    mat_next = ram_rdata;
                    w_next   = CNT_W'(1);
                end
                else
                begin
                    col_next = col_reg + S_W'(1);
                end
            end
            ST_RUN:
            begin
                if (!col_in)
                begin
                    h_next = CNT_W'(1);
                    j_next = '0;
                end
            end
            ST_RUN_CK:
            begin
                if (match)
                begin
                    w_next = w_reg + CNT_W'(1);
                end
                else
                begin
                    h_next = CNT_W'(1);
                    j_next = '0;
                end
            end
            ST_ROW:
            begin
                if (!row_in)
                begin
                    i_next = '0;
                    j_next = '0;
                end
            end
            ST_ROW_CK:
            begin
                if (!match)
                begin
                    i_next = '0;
                    j_next = '0;
                end
                else if (j_last)
                begin
                    h_next = h_reg + CNT_W'(1);
                    j_next = '0;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (j_last)
                begin
                    j_next = '0;
                    if (i_last)
                    begin
                        res_next.found         = 1'b1;
                        res_next.rect_row      = ROW_W'(row_reg);
                        res_next.rect_col      = COL_W'(col_reg);
                        res_next.rect_width    = SIZE_W'(w_reg);
                        res_next.rect_height   = SIZE_W'(h_reg);
                        res_next.rect_material = MAT_W'(mat_reg);
                        done_next              = 1'b1;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        h_reg   <= h_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        mat_reg <= mat_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: test/greedy_rectangle_merge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_rectangle_merge_checker
// Watches the item, result and register ports of the merge core, keeps its
// own copy of the grid, cursor and extents, predicts the rectangle of every
// fetch item and compares each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module greedy_rectangle_merge_checker #(
    parameter int GRID_DIM = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       op,
    input  logic [grm_pkg::ROW_W-1:0]  cell_row,
    input  logic [grm_pkg::COL_W-1:0]  cell_col,
    input  logic [grm_pkg::MAT_W-1:0]  cell_material,
    input  logic                       done,
    input  logic                       found,
    input  logic [grm_pkg::ROW_W-1:0]  rect_row,
    input  logic [grm_pkg::COL_W-1:0]  rect_col,
    input  logic [grm_pkg::SIZE_W-1:0] rect_width,
    input  logic [grm_pkg::SIZE_W-1:0] rect_height,
    input  logic [grm_pkg::MAT_W-1:0]  rect_material,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [grm_pkg::CFG_W-1:0]  cfg_data,
    output int                         fail_count,
    output int                         pending_results
);
    import grm_pkg::*;

    logic [MAT_W-1:0] grid [GRID_DIM][GRID_DIM];
    logic [CFG_W-1:0] row_extent;
    logic [CFG_W-1:0] col_extent;
    int               cursor_row;
    int               cursor_col;
    grm_result_t      expected_rects [$];

    // Finds the next rectangle from the cursor, clears it and moves the cursor.
    function automatic grm_result_t next_rectangle();
        grm_result_t      res;
        int               rows;
        int               cols;
        int               r;
        int               c;
        int               w;
        int               h;
        int               i;
        int               j;
        logic [MAT_W-1:0] mat;
        bit               searching;
        bit               grow;

        res  = '0;
        rows = (row_extent > GRID_DIM) ? GRID_DIM : row_extent;
        cols = (col_extent > GRID_DIM) ? GRID_DIM : col_extent;
        r    = cursor_row;
        c    = cursor_col;
        searching = 1'b1;
        while (searching)
        begin
            if (c >= cols)
            begin
                r++;
                c = 0;
            end
            if (r >= rows)
                searching = 1'b0;
            else if (grid[r][c] != '0)
                searching = 1'b0;
            else
                c++;
        end

        if (r >= rows || cols == 0)
        begin
            cursor_row = GRID_DIM;
            cursor_col = 0;
            return res;
        end

        mat = grid[r][c];
        w = 1;
        while (c + w < cols && grid[r][c + w] == mat)
            w++;
        h = 1;
        grow = 1'b1;
        while (r + h < rows && grow)
        begin
            for (j = 0; j < w; j++)
                if (grid[r + h][c + j] != mat)
                    grow = 1'b0;
            if (grow)
                h++;
        end
        for (i = 0; i < h; i++)
            for (j = 0; j < w; j++)
                grid[r + i][c + j] = '0;

        cursor_row = r;
        cursor_col = c;

        res.found         = 1'b1;
        res.rect_row      = r[ROW_W-1:0];
        res.rect_col      = c[COL_W-1:0];
        res.rect_width    = w[SIZE_W-1:0];
        res.rect_height   = h[SIZE_W-1:0];
        res.rect_material = mat;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grm_result_t want;

        if (!rst_n)
        begin
            for (int r = 0; r < GRID_DIM; r++)
                for (int c = 0; c < GRID_DIM; c++)
                    grid[r][c] = '0;
            row_extent = ROW_COUNT_RST;
            col_extent = COL_COUNT_RST;
            cursor_row = 0;
            cursor_col = 0;
            expected_rects.delete();
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_rects.size() == 0)
                begin
                    $error("result strobe with no fetch item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_rects.pop_front();
                    check_field("found", want.found, found);
                    check_field("rect_row", want.rect_row, rect_row);
                    check_field("rect_col", want.rect_col, rect_col);
                    check_field("rect_width", want.rect_width, rect_width);
                    check_field("rect_height", want.rect_height, rect_height);
                    check_field("rect_material", want.rect_material, rect_material);
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == REG_ROW_COUNT)
                    row_extent = cfg_data;
                else
                    col_extent = cfg_data;
            end

            if (start && !busy)
            begin
                if (op == OP_LOAD)
                begin
                    grid[cell_row][cell_col] = cell_material;
                    cursor_row = 0;
                    cursor_col = 0;
                end
                else
                begin
                    want = next_rectangle();
                    expected_rects.insert(expected_rects.size(), want);
                end
            end

            pending_results = expected_rects.size();
        end
    end

endmodule

// File: test/greedy_rectangle_merge_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_rectangle_merge_core_tb
// Drives load and fetch items into the merge core under changing extents and
// sender idling; the checker beside the core predicts and compares results.
// ----------------------------------------------------------------------------
module greedy_rectangle_merge_core_tb;
    import grm_pkg::*;

    localparam int GRID_DIM      = 32;
    // the grid preload already sends one item per cell
    localparam int RANDOM_ITEMS  = 560;
    localparam int PHASE_ITEMS   = 140;
    localparam int SETTLE_CYCLES = 16;
    // covers a few hundred fetches at their worst, many times over
    localparam int CYCLE_LIMIT   = 15_000_000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              op;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic [MAT_W-1:0]  cell_material;
    logic              done;
    logic              found;
    logic [ROW_W-1:0]  rect_row;
    logic [COL_W-1:0]  rect_col;
    logic [SIZE_W-1:0] rect_width;
    logic [SIZE_W-1:0] rect_height;
    logic [MAT_W-1:0]  rect_material;
    logic              cfg_we;
    logic [0:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int fail_count;
    int pending_results;
    int idle_pct;
    int items_sent;
    int cycle_count;
    int row_setting;
    int col_setting;

    greedy_rectangle_merge_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .cell_material (cell_material),
        .done          (done),
        .found         (found),
        .rect_row      (rect_row),
        .rect_col      (rect_col),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .rect_material (rect_material),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    greedy_rectangle_merge_checker #(
        .GRID_DIM (GRID_DIM)
    ) merge_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .cell_row        (cell_row),
        .cell_col        (cell_col),
        .cell_material   (cell_material),
        .done            (done),
        .found           (found),
        .rect_row        (rect_row),
        .rect_col        (rect_col),
        .rect_width      (rect_width),
        .rect_height     (rect_height),
        .rect_material   (rect_material),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** greedy_rectangle_merge_core: FAILED **");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // without touching start, so back-to-back items keep start high.
    task automatic send_item(input logic item_op, input int row, input int col,
                             input int mat);
        while ($urandom_range(99) < idle_pct)
        begin
            start         <= 1'b0;
            op            <= $urandom_range(1);
            cell_row      <= $urandom_range(31);
            cell_col      <= $urandom_range(31);
            cell_material <= $urandom_range(255);
            @(negedge clk);
        end
        start         <= 1'b1;
        op            <= item_op;
        cell_row      <= row[ROW_W-1:0];
        cell_col      <= col[COL_W-1:0];
        cell_material <= mat[MAT_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_cell(input int row, input int col, input int mat);
        send_item(OP_LOAD, row, col, mat);
    endtask

    task automatic fetch_rect();
        send_item(OP_FETCH, $urandom_range(31), $urandom_range(31), $urandom_range(255));
    endtask

    // Holds off the sender until every fetch has reported and the core is idle.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_extents(input int rows, input int cols);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= rows[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= REG_COL_COUNT;
        cfg_data  <= cols[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        row_setting = rows;
        col_setting = cols;
    endtask

    function automatic int pick_extent();
        int sel;

        sel = $urandom_range(99);
        if (sel < 80)
            return $urandom_range(1, 8);
        else if (sel < 92)
            return $urandom_range(9, 32);
        else if (sel < 97)
            return $urandom_range(33, 63);
        return 0;
    endfunction

    // One layer: maybe new extents, paint overlapping blocks, then fetch them
    // back with the odd stray load thrown in to rewind the cursor.
    task automatic run_layer();
        int eff_rows;
        int eff_cols;
        int n_blocks;
        int n_fetch;
        int r0;
        int c0;
        int hh;
        int ww;
        int mat;
        int palette [3];

        if ($urandom_range(2) == 0)
            set_extents(pick_extent(), pick_extent());
        else if ($urandom_range(5) == 0)
            drain_results();

        eff_rows = (row_setting > GRID_DIM) ? GRID_DIM : row_setting;
        eff_cols = (col_setting > GRID_DIM) ? GRID_DIM : col_setting;
        if (eff_rows == 0)
            eff_rows = 4;
        if (eff_cols == 0)
            eff_cols = 4;

        palette[0] = $urandom_range(1, 255);
        if ($urandom_range(3) == 0)
        begin
            palette[1] = palette[0];
            palette[2] = palette[0];
        end
        else
        begin
            palette[1] = $urandom_range(1, 255);
            palette[2] = $urandom_range(1, 255);
        end

        n_blocks = $urandom_range(1, 5);
        for (int k = 0; k < n_blocks; k++)
        begin
            mat = ($urandom_range(7) == 0) ? 0 : palette[$urandom_range(2)];
            if ($urandom_range(9) == 0)
            begin
                r0 = $urandom_range(31);
                c0 = $urandom_range(31);
            end
            else
            begin
                r0 = $urandom_range(eff_rows - 1);
                c0 = $urandom_range(eff_cols - 1);
            end
            hh = $urandom_range(1, 3);
            ww = $urandom_range(1, 4);
            for (int i = 0; i < hh; i++)
                for (int j = 0; j < ww; j++)
                    if (r0 + i < GRID_DIM && c0 + j < GRID_DIM)
                        load_cell(r0 + i, c0 + j, mat);
        end

        n_fetch = 2 * n_blocks + $urandom_range(1, 2);
        for (int k = 0; k < n_fetch; k++)
        begin
            if ($urandom_range(11) == 0)
                load_cell($urandom_range(31), $urandom_range(31), $urandom_range(255));
            fetch_rect();
        end
    endtask

    initial
    begin
        int random_base;
        int idle_phases [4];

        idle_phases[0] = 0;
        idle_phases[1] = 67;
        idle_phases[2] = 0;
        idle_phases[3] = 21;

        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_LOAD;
        cell_row      = '0;
        cell_col      = '0;
        cell_material = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_ROW_COUNT;
        cfg_data      = '0;
        idle_pct      = 0;
        items_sent    = 0;
        row_setting   = 32;
        col_setting   = 32;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every cell gets written before any fetch can scan it
        for (int r = 0; r < GRID_DIM; r++)
            for (int c = 0; c < GRID_DIM; c++)
                load_cell(r, c, 0);

        idle_pct = 21;
        set_extents(32, 32);
        // 2x2 block of max material at the origin, lone cell in the far corner
        load_cell(0, 0, 255);
        load_cell(0, 1, 255);
        load_cell(1, 0, 255);
        load_cell(1, 1, 255);
        load_cell(31, 31, 1);
        fetch_rect();
        fetch_rect();
        fetch_rect();
        fetch_rect();

        // zero rows, then zero columns: nothing can be found
        set_extents(0, 63);
        load_cell(2, 3, 8'h55);
        fetch_rect();
        set_extents(63, 0);
        load_cell(2, 4, 8'h55);
        fetch_rect();

        // oversized extents behave as the full grid
        set_extents(63, 63);
        load_cell(2, 5, 8'hAA);
        fetch_rect();
        fetch_rect();
        fetch_rect();

        // one-cell extent cuts the run short
        set_extents(1, 1);
        load_cell(0, 0, 3);
        load_cell(0, 1, 3);
        fetch_rect();
        fetch_rect();

        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            idle_pct = idle_phases[((items_sent - random_base) / PHASE_ITEMS) % 4];
            run_layer();
        end

        drain_results();

        if (fail_count == 0)
            $display("** greedy_rectangle_merge_core: PASSED **");
        else
            $display("** greedy_rectangle_merge_core: FAILED **");
        $finish;
    end

endmodule
